[hw/rtl/fltsc_pkg.sv]
// Shared types and constants for the fuzzy light tracking servo controller.
// Used by the controller, datapath, divider and top level; no dependencies.
`default_nettype none

package fltsc_pkg;

  localparam int ONE_Q      = 16384;  // 1.0 in Q1.14
  localparam int DIM_FLOOR  = 10;
  localparam int FIRE_LEVEL = 60;
  localparam int DIV_W      = 56;
  localparam int DIV_CNT_W  = 6;
  localparam int STEP_W     = 5;

  localparam logic signed [15:0] RST_LU   = -16'sd16384;
  localparam logic signed [15:0] RST_LL   = -16'sd8192;
  localparam logic signed [15:0] RST_RU   = 16'sd16384;
  localparam logic signed [15:0] RST_RL   = 16'sd8192;
  localparam logic [7:0]         RST_PMIN = 8'd50;
  localparam logic [7:0]         RST_PMAX = 8'd150;
  localparam logic [15:0]        RST_PER  = 16'd20;

  typedef enum logic [2:0] {
    REG_LU     = 3'd0,
    REG_LL     = 3'd1,
    REG_RU     = 3'd2,
    REG_RL     = 3'd3,
    REG_PMIN   = 3'd4,
    REG_PMAX   = 3'd5,
    REG_PERIOD = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] lu;
    logic [15:0] ll;
    logic [15:0] ru;
    logic [15:0] rl;
    logic [7:0]  pmin;
    logic [7:0]  pmax;
    logic [15:0] period;
  } cfg_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_MDIV,
    CMD_MWB,
    CMD_RULES,
    CMD_MUL,
    CMD_WB,
    CMD_FDIV,
    CMD_FWB,
    CMD_FINISH
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [STEP_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic no_rule;
    logic area_pos;
  } status_t;

  localparam logic [STEP_W-1:0] SAMPLE_LAST = 5'd3;

  // Product sequence for breakpoints, area and moment
  localparam logic [STEP_W-1:0] STP_P0      = 5'd0;
  localparam logic [STEP_W-1:0] STP_P1      = 5'd1;
  localparam logic [STEP_W-1:0] STP_P2      = 5'd2;
  localparam logic [STEP_W-1:0] STP_P3      = 5'd3;
  localparam logic [STEP_W-1:0] STP_A_R0P0  = 5'd4;
  localparam logic [STEP_W-1:0] STP_A_R1MID = 5'd5;
  localparam logic [STEP_W-1:0] STP_A_R2TOP = 5'd6;
  localparam logic [STEP_W-1:0] STP_D01S    = 5'd7;
  localparam logic [STEP_W-1:0] STP_N_D01P0 = 5'd8;
  localparam logic [STEP_W-1:0] STP_D23S    = 5'd9;
  localparam logic [STEP_W-1:0] STP_N_D23P2 = 5'd10;
  localparam logic [STEP_W-1:0] STP_D01SQ   = 5'd11;
  localparam logic [STEP_W-1:0] STP_N_D01SQ = 5'd12;
  localparam logic [STEP_W-1:0] STP_D23SQ   = 5'd13;
  localparam logic [STEP_W-1:0] STP_N_D23SQ = 5'd14;
  localparam logic [STEP_W-1:0] STP_P0SQ    = 5'd15;
  localparam logic [STEP_W-1:0] STP_N_P0SQ  = 5'd16;
  localparam logic [STEP_W-1:0] STP_P2SQ    = 5'd17;
  localparam logic [STEP_W-1:0] STP_P1SQ    = 5'd18;
  localparam logic [STEP_W-1:0] STP_N_P21SQ = 5'd19;
  localparam logic [STEP_W-1:0] STP_P3SQ    = 5'd20;
  localparam logic [STEP_W-1:0] STP_N_P3SQ  = 5'd21;
  localparam logic [STEP_W-1:0] STP_LAST    = 5'd21;

endpackage

`default_nettype wire

[hw/rtl/fltsc_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on fltsc_pkg for widths.
`default_nettype none

module fltsc_div #(
  parameter int SHORT_W = 27
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic                         short_mode,
  input  wire logic [fltsc_pkg::DIV_W-1:0]  num,
  input  wire logic [fltsc_pkg::DIV_W-1:0]  den,
  output logic                              done,
  output logic [fltsc_pkg::DIV_W-1:0]       quo,
  output logic                              rem_nz
);

  localparam int DW = fltsc_pkg::DIV_W;
  localparam int CW = fltsc_pkg::DIV_CNT_W;

  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic [DW+1:0] trial;

  always_comb begin
    trial   = {1'b0, rem_r, quo_r[DW-1]} - {2'b00, den_r};
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    if (start) begin
      rem_nxt = '0;
      // short dividends are left-aligned so only their bits are iterated
      quo_nxt = short_mode ? (num << (DW - SHORT_W)) : num;
      den_nxt = den;
      cnt_nxt = short_mode ? CW'(SHORT_W) : CW'(DW);
      run_nxt = 1'b1;
    end else if (run_r && (cnt_r != '0)) begin
      if (!trial[DW+1]) begin
        rem_nxt = trial[DW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DW-2:0], quo_r[DW-1]};
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end else if (run_r) begin
      run_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done   = run_r && (cnt_r == '0);
  assign quo    = quo_r;
  assign rem_nz = (rem_r != '0);

endmodule

`default_nettype wire

[hw/rtl/fltsc_dpath.sv]
// Datapath: sample capture, memberships, rules, product sequence, action and
// servo update. Depends on fltsc_pkg and fltsc_div.
`default_nettype none

module fltsc_dpath #(
  parameter int SAMPLE_BITS  = 10,
  parameter int SERVO_CENTER = 100
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire fltsc_pkg::cmd_t        cmd,
  output fltsc_pkg::status_t          st,
  input  wire fltsc_pkg::cfg_t        cfg,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_a,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_b,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_c,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_d,
  input  wire logic [31:0]            in_now_ms,
  output logic [7:0]                  out_servo_position,
  output logic signed [8:0]           out_angle_from_middle,
  output logic signed [15:0]          out_fuzzy_action,
  output logic                        out_position_written,
  output logic                        out_fire_seen
);

  localparam int SB = SAMPLE_BITS;
  localparam int DW = fltsc_pkg::DIV_W;

  function automatic logic [14:0] mn2(input logic [14:0] a, input logic [14:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [14:0] mx2(input logic [14:0] a, input logic [14:0] b);
    return (a > b) ? a : b;
  endfunction

  // captured word
  logic [SB-1:0] x_r [4];
  logic [31:0]   now_r;
  logic [SB-1:0] lo_r, hi_r;
  logic          fire_r;

  logic [14:0]   dm_r [4];
  logic [14:0]   r0_r, r1_r, r2_r;
  logic signed [17:0] p_r [4];
  logic signed [56:0] prod_r;
  logic signed [36:0] t_r;
  logic signed [39:0] acca_r;
  logic signed [56:0] accn_r;
  logic          neg_r;
  logic signed [15:0] act_r;
  logic [7:0]    pos_r;
  logic [31:0]   last_r;

  logic [7:0]         opos_r;
  logic signed [8:0]  oang_r;
  logic signed [15:0] oact_r;
  logic               owr_r, ofire_r;

  // load
  logic [SB-1:0] mn_ab, mn_cd, mn, mx_ab, mx_cd, mx, lo_nxt;
  logic [SB+1:0] sum;

  always_comb begin
    mn_ab  = (in_sample_a < in_sample_b) ? in_sample_a : in_sample_b;
    mn_cd  = (in_sample_c < in_sample_d) ? in_sample_c : in_sample_d;
    mn     = (mn_ab < mn_cd) ? mn_ab : mn_cd;
    mx_ab  = (in_sample_a > in_sample_b) ? in_sample_a : in_sample_b;
    mx_cd  = (in_sample_c > in_sample_d) ? in_sample_c : in_sample_d;
    mx     = (mx_ab > mx_cd) ? mx_ab : mx_cd;
    lo_nxt = (mn < SB'(fltsc_pkg::DIM_FLOOR)) ? SB'(fltsc_pkg::DIM_FLOOR) : mn;
    sum    = (SB+2)'(in_sample_a) + (SB+2)'(in_sample_b)
           + (SB+2)'(in_sample_c) + (SB+2)'(in_sample_d);
  end

  // membership division operands
  logic [SB-1:0] xs, hmx, diff;
  logic          flat;
  logic [DW-1:0] mnum, mden;

  always_comb begin
    xs   = x_r[cmd.idx[1:0]];
    hmx  = hi_r - xs;
    diff = hi_r - lo_r;
    flat = (hi_r <= lo_r) || (xs < lo_r);
    mnum = DW'({hmx, 15'b0}) + DW'(diff);
    mden = DW'({diff, 1'b0});
  end

  // rules
  logic [14:0] br0, br1, br2, br3;
  logic [14:0] r0_nxt, r1_nxt, r2_nxt;

  always_comb begin
    br0    = 15'(fltsc_pkg::ONE_Q) - dm_r[0];
    br1    = 15'(fltsc_pkg::ONE_Q) - dm_r[1];
    br2    = 15'(fltsc_pkg::ONE_Q) - dm_r[2];
    br3    = 15'(fltsc_pkg::ONE_Q) - dm_r[3];
    r0_nxt = mx2(mn2(mn2(br0, dm_r[2]), dm_r[3]),
                 mn2(mn2(dm_r[0], br1), mn2(dm_r[2], dm_r[3])));
    r1_nxt = mn2(br1, br2);
    r2_nxt = mx2(mn2(mn2(dm_r[0], dm_r[1]), br3),
                 mn2(mn2(dm_r[0], dm_r[1]), mn2(br2, br3)));
  end

  // product operands
  logic signed [15:0] lu, ll, ru, rl;
  logic signed [16:0] d_ll_lu, d_lu_ll, d_rl_ru, d_ru_rl;
  logic signed [18:0] d01, d23, p21, top3;
  logic signed [19:0] p0x3, p2x3;
  logic [16:0]        r0x2, r1x2, r2x2, r0x3, r1x3, r2x3, rs01, rs12, w01, w12;
  logic signed [36:0] op_a;
  logic signed [19:0] op_b;

  always_comb begin
    lu      = cfg.lu;
    ll      = cfg.ll;
    ru      = cfg.ru;
    rl      = cfg.rl;
    d_ll_lu = 17'(ll) - 17'(lu);
    d_lu_ll = 17'(lu) - 17'(ll);
    d_rl_ru = 17'(rl) - 17'(ru);
    d_ru_rl = 17'(ru) - 17'(rl);
    d01     = 19'(p_r[1]) - 19'(p_r[0]);
    d23     = 19'(p_r[3]) - 19'(p_r[2]);
    p21     = 19'(p_r[2]) - 19'(p_r[1]);
    top3    = 19'sd32768 - 19'(p_r[3]);
    p0x3    = 20'(p_r[0]) + (20'(p_r[0]) <<< 1);
    p2x3    = 20'(p_r[2]) + (20'(p_r[2]) <<< 1);
    r0x2    = {1'b0, r0_r, 1'b0};
    r1x2    = {1'b0, r1_r, 1'b0};
    r2x2    = {1'b0, r2_r, 1'b0};
    r0x3    = r0x2 + 17'(r0_r);
    r1x3    = r1x2 + 17'(r1_r);
    r2x3    = r2x2 + 17'(r2_r);
    rs01    = 17'(r0_r) + 17'(r1_r);
    rs12    = 17'(r1_r) + 17'(r2_r);
    w01     = 17'(r0_r) + r1x2;
    w12     = 17'(r1_r) + r2x2;
    op_a    = '0;
    op_b    = '0;
    unique case (cmd.idx)
      fltsc_pkg::STP_P0:      begin op_a = 37'(d_ll_lu); op_b = 20'(r0_r); end
      fltsc_pkg::STP_P1:      begin op_a = 37'(d_lu_ll); op_b = 20'(r1_r); end
      fltsc_pkg::STP_P2:      begin op_a = 37'(d_rl_ru); op_b = 20'(r1_r); end
      fltsc_pkg::STP_P3:      begin op_a = 37'(d_ru_rl); op_b = 20'(r2_r); end
      fltsc_pkg::STP_A_R0P0:  begin op_a = 37'(p_r[0]);  op_b = 20'(r0x2); end
      fltsc_pkg::STP_A_R1MID: begin op_a = 37'(p21);     op_b = 20'(r1x2); end
      fltsc_pkg::STP_A_R2TOP: begin op_a = 37'(top3);    op_b = 20'(r2x2); end
      fltsc_pkg::STP_D01S:    begin op_a = 37'(d01);     op_b = 20'(rs01); end
      fltsc_pkg::STP_N_D01P0: begin op_a = t_r;          op_b = p0x3;      end
      fltsc_pkg::STP_D23S:    begin op_a = 37'(d23);     op_b = 20'(rs12); end
      fltsc_pkg::STP_N_D23P2: begin op_a = t_r;          op_b = p2x3;      end
      fltsc_pkg::STP_D01SQ:   begin op_a = 37'(d01);     op_b = 20'(d01);  end
      fltsc_pkg::STP_N_D01SQ: begin op_a = t_r;          op_b = 20'(w01);  end
      fltsc_pkg::STP_D23SQ:   begin op_a = 37'(d23);     op_b = 20'(d23);  end
      fltsc_pkg::STP_N_D23SQ: begin op_a = t_r;          op_b = 20'(w12);  end
      fltsc_pkg::STP_P0SQ:    begin op_a = 37'(p_r[0]);  op_b = 20'(p_r[0]); end
      fltsc_pkg::STP_N_P0SQ:  begin op_a = t_r;          op_b = 20'(r0x3); end
      fltsc_pkg::STP_P2SQ:    begin op_a = 37'(p_r[2]);  op_b = 20'(p_r[2]); end
      fltsc_pkg::STP_P1SQ:    begin op_a = 37'(p_r[1]);  op_b = 20'(p_r[1]); end
      fltsc_pkg::STP_N_P21SQ: begin op_a = t_r;          op_b = 20'(r1x3); end
      fltsc_pkg::STP_P3SQ:    begin op_a = 37'(p_r[3]);  op_b = 20'(p_r[3]); end
      fltsc_pkg::STP_N_P3SQ:  begin op_a = t_r;          op_b = 20'(r2x3); end
      default:                begin op_a = '0;           op_b = '0;        end
    endcase
  end

  // breakpoint writeback: base + round(prod / ONE_Q) + ONE_Q
  logic signed [56:0] prnd;
  logic signed [15:0] pbase;
  logic signed [19:0] pw;

  always_comb begin
    prnd = (prod_r + 57'sd8192) >>> 14;
    unique case (cmd.idx)
      fltsc_pkg::STP_P0: pbase = lu;
      fltsc_pkg::STP_P1: pbase = ll;
      fltsc_pkg::STP_P2: pbase = ru;
      default:           pbase = rl;
    endcase
    pw = 20'(pbase) + $signed(prnd[19:0]) + 20'sd16384;
  end

  // final division operands
  logic signed [57:0] nfull, nmag;
  logic signed [43:0] den6;
  logic [DW-1:0]      dnum, dden, quo;
  logic               dstart, dshort, ddone, rem_nz;

  always_comb begin
    nfull  = (58'(accn_r) <<< 1) + 58'(acca_r) + (58'(acca_r) <<< 1);
    nmag   = nfull[57] ? -nfull : nfull;
    den6   = (44'(acca_r) <<< 1) + (44'(acca_r) <<< 2);
    dstart = (cmd.op == fltsc_pkg::CMD_MDIV) || (cmd.op == fltsc_pkg::CMD_FDIV);
    dshort = (cmd.op == fltsc_pkg::CMD_MDIV);
    dnum   = dshort ? mnum : nmag[DW-1:0];
    dden   = dshort ? mden : DW'(den6);
  end

  fltsc_div #(
    .SHORT_W (SB + 17)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (dstart),
    .short_mode (dshort),
    .num        (dnum),
    .den        (dden),
    .done       (ddone),
    .quo        (quo),
    .rem_nz     (rem_nz)
  );

  // action from quotient: floor division, then offset and saturate
  logic signed [57:0] qa, qf, actw;
  logic signed [15:0] act_nxt;

  always_comb begin
    qa   = 58'(quo) + 58'(rem_nz && neg_r);
    qf   = neg_r ? -qa : qa;
    actw = qf - 58'sd16384;
    if (actw > 58'sd16384) begin
      act_nxt = 16'sd16384;
    end else if (actw < -58'sd16384) begin
      act_nxt = -16'sd16384;
    end else begin
      act_nxt = actw[15:0];
    end
  end

  // servo update
  logic [31:0]        elapsed;
  logic               upd;
  logic [15:0]        magu;
  logic [19:0]        mag10, stp;
  logic signed [10:0] posn;
  logic [7:0]         pos_new;
  logic signed [9:0]  ang;

  always_comb begin
    elapsed = now_r - last_r;
    upd     = elapsed > {16'b0, cfg.period};
    magu    = act_r[15] ? 16'(-act_r) : 16'(act_r);
    mag10   = (20'(magu) << 3) + (20'(magu) << 1);
    stp     = (mag10 + 20'd8192) >> 14;
    posn    = act_r[15] ? ($signed({3'b0, pos_r}) + $signed({6'b0, stp[4:0]}))
                        : ($signed({3'b0, pos_r}) - $signed({6'b0, stp[4:0]}));
    pos_new = pos_r;
    if (upd) begin
      if (posn > $signed({3'b0, cfg.pmax})) begin
        pos_new = cfg.pmax;
      end else if (posn < $signed({3'b0, cfg.pmin})) begin
        pos_new = cfg.pmin;
      end else begin
        pos_new = posn[7:0];
      end
      // min limit wins when the limits are crossed
      if (pos_new < cfg.pmin) begin
        pos_new = cfg.pmin;
      end
    end
    ang = 10'(SERVO_CENTER) - $signed({2'b0, pos_new});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 8'(SERVO_CENTER);
      last_r <= '0;
    end else if (cmd.op == fltsc_pkg::CMD_FINISH && upd) begin
      pos_r  <= pos_new;
      last_r <= now_r;
    end
    case (cmd.op)
      fltsc_pkg::CMD_LOAD: begin
        x_r[0] <= in_sample_a;
        x_r[1] <= in_sample_b;
        x_r[2] <= in_sample_c;
        x_r[3] <= in_sample_d;
        now_r  <= in_now_ms;
        lo_r   <= lo_nxt;
        hi_r   <= mx;
        fire_r <= sum > (SB+2)'(fltsc_pkg::FIRE_LEVEL);
        act_r  <= '0;
      end
      fltsc_pkg::CMD_MWB: begin
        dm_r[cmd.idx[1:0]] <= flat ? 15'(fltsc_pkg::ONE_Q) : quo[14:0];
      end
      fltsc_pkg::CMD_RULES: begin
        r0_r   <= r0_nxt;
        r1_r   <= r1_nxt;
        r2_r   <= r2_nxt;
        acca_r <= '0;
        accn_r <= '0;
        t_r    <= '0;
      end
      fltsc_pkg::CMD_MUL: begin
        prod_r <= op_a * op_b;
      end
      fltsc_pkg::CMD_WB: begin
        case (cmd.idx)
          fltsc_pkg::STP_P0, fltsc_pkg::STP_P1, fltsc_pkg::STP_P2, fltsc_pkg::STP_P3: begin
            p_r[cmd.idx[1:0]] <= pw[17:0];
          end
          fltsc_pkg::STP_A_R0P0, fltsc_pkg::STP_A_R1MID, fltsc_pkg::STP_A_R2TOP: begin
            acca_r <= acca_r + 40'(prod_r);
          end
          fltsc_pkg::STP_D01S, fltsc_pkg::STP_D23S: begin
            t_r    <= 37'(prod_r);
            acca_r <= acca_r + 40'(prod_r);
          end
          fltsc_pkg::STP_D01SQ, fltsc_pkg::STP_D23SQ, fltsc_pkg::STP_P0SQ,
          fltsc_pkg::STP_P2SQ: begin
            t_r <= 37'(prod_r);
          end
          fltsc_pkg::STP_P1SQ: begin
            t_r <= t_r - 37'(prod_r);
          end
          fltsc_pkg::STP_P3SQ: begin
            // 4 * ONE_Q^2 less p3 squared
            t_r <= 37'sd1073741824 - 37'(prod_r);
          end
          default: begin
            accn_r <= accn_r + prod_r;
          end
        endcase
      end
      fltsc_pkg::CMD_FDIV: begin
        neg_r <= nfull[57];
      end
      fltsc_pkg::CMD_FWB: begin
        act_r <= act_nxt;
      end
      fltsc_pkg::CMD_FINISH: begin
        opos_r  <= pos_new;
        oang_r  <= ang[8:0];
        oact_r  <= act_r;
        owr_r   <= upd;
        ofire_r <= fire_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    st.div_done = ddone;
    st.no_rule  = (r0_r == '0) && (r1_r == '0) && (r2_r == '0);
    st.area_pos = (acca_r > 40'sd0);
  end

  assign out_servo_position    = opos_r;
  assign out_angle_from_middle = oang_r;
  assign out_fuzzy_action      = oact_r;
  assign out_position_written  = owr_r;
  assign out_fire_seen         = ofire_r;

endmodule

`default_nettype wire

[hw/rtl/fltsc_ctrl.sv]
// Sequencer: steps the datapath through capture, memberships, rules,
// products, final division and servo update. Depends on fltsc_pkg.
`default_nettype none

module fltsc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output fltsc_pkg::cmd_t          cmd,
  input  wire fltsc_pkg::status_t  st
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MDIV,
    ST_MWAIT,
    ST_RULES,
    ST_MUL,
    ST_WB,
    ST_AREA,
    ST_FWAIT,
    ST_FINISH
  } state_t;

  state_t                       state_r, state_nxt;
  logic [fltsc_pkg::STEP_W-1:0] idx_r, idx_nxt;
  logic                         out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    cmd.op        = fltsc_pkg::CMD_NONE;
    cmd.idx       = idx_r;
    in_ready      = (state_r == ST_IDLE);
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = fltsc_pkg::CMD_LOAD;
          idx_nxt   = '0;
          state_nxt = ST_MDIV;
        end
      end
      ST_MDIV: begin
        cmd.op    = fltsc_pkg::CMD_MDIV;
        state_nxt = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (st.div_done) begin
          cmd.op = fltsc_pkg::CMD_MWB;
          if (idx_r == fltsc_pkg::SAMPLE_LAST) begin
            state_nxt = ST_RULES;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_MDIV;
          end
        end
      end
      ST_RULES: begin
        cmd.op    = fltsc_pkg::CMD_RULES;
        idx_nxt   = fltsc_pkg::STP_P0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        // no rule fired: action stays zero
        if (st.no_rule) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.op    = fltsc_pkg::CMD_MUL;
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        cmd.op = fltsc_pkg::CMD_WB;
        if (idx_r == fltsc_pkg::STP_LAST) begin
          state_nxt = ST_AREA;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_AREA: begin
        if (st.area_pos) begin
          cmd.op    = fltsc_pkg::CMD_FDIV;
          state_nxt = ST_FWAIT;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FWAIT: begin
        if (st.div_done) begin
          cmd.op    = fltsc_pkg::CMD_FWB;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.op        = fltsc_pkg::CMD_FINISH;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_finish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == fltsc_pkg::CMD_FINISH) |-> (!out_valid_r || out_ready))
    else $error("result written over an untaken word");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    st.div_done |-> (state_r == ST_MWAIT || state_r == ST_FWAIT))
    else $error("divider done outside a wait state");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_MDIV && idx_r == '0))
    else $error("accepted word did not start membership pass");
`endif

endmodule

`default_nettype wire

[hw/rtl/fuzzy_light_tracking_servo_controller.sv]
// Each accepted word runs capture, four membership divisions, rules, the
// 22-step product sequence, final division and servo update; with no rule
// firing, the products and final division are skipped. A new word is taken
// only once the last is done. The shared one-bit-per-cycle divider (four
// membership, one 56-bit centroid division) and one multiplier set the rate.
// Reset: synchronous active-low; config registers to defaults, servo to center.
`default_nettype none

module fuzzy_light_tracking_servo_controller #(
  parameter int SERVO_CENTER = 100,
  parameter int SAMPLE_BITS  = 10
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [2:0]             cfg_index,
  input  wire logic [15:0]            cfg_wdata,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_a,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_b,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_c,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_d,
  input  wire logic [31:0]            in_now_ms,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [7:0]                  out_servo_position,
  output logic signed [8:0]           out_angle_from_middle,
  output logic signed [15:0]          out_fuzzy_action,
  output logic                        out_position_written,
  output logic                        out_fire_seen
);

  fltsc_pkg::cfg_t    cfg_r, cfg_nxt;
  fltsc_pkg::cmd_t    cmd;
  fltsc_pkg::status_t st;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (fltsc_pkg::reg_idx_t'(cfg_index))
        fltsc_pkg::REG_LU:     cfg_nxt.lu     = cfg_wdata;
        fltsc_pkg::REG_LL:     cfg_nxt.ll     = cfg_wdata;
        fltsc_pkg::REG_RU:     cfg_nxt.ru     = cfg_wdata;
        fltsc_pkg::REG_RL:     cfg_nxt.rl     = cfg_wdata;
        fltsc_pkg::REG_PMIN:   cfg_nxt.pmin   = cfg_wdata[7:0];
        fltsc_pkg::REG_PMAX:   cfg_nxt.pmax   = cfg_wdata[7:0];
        fltsc_pkg::REG_PERIOD: cfg_nxt.period = cfg_wdata;
        default:               cfg_nxt        = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lu     <= fltsc_pkg::RST_LU;
      cfg_r.ll     <= fltsc_pkg::RST_LL;
      cfg_r.ru     <= fltsc_pkg::RST_RU;
      cfg_r.rl     <= fltsc_pkg::RST_RL;
      cfg_r.pmin   <= fltsc_pkg::RST_PMIN;
      cfg_r.pmax   <= fltsc_pkg::RST_PMAX;
      cfg_r.period <= fltsc_pkg::RST_PER;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fltsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .st        (st)
  );

  fltsc_dpath #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .SERVO_CENTER (SERVO_CENTER)
  ) u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .st                    (st),
    .cfg                   (cfg_r),
    .in_sample_a           (in_sample_a),
    .in_sample_b           (in_sample_b),
    .in_sample_c           (in_sample_c),
    .in_sample_d           (in_sample_d),
    .in_now_ms             (in_now_ms),
    .out_servo_position    (out_servo_position),
    .out_angle_from_middle (out_angle_from_middle),
    .out_fuzzy_action      (out_fuzzy_action),
    .out_position_written  (out_position_written),
    .out_fire_seen         (out_fire_seen)
  );

endmodule

`default_nettype wire

[verif/tb_fuzzy_light_tracking_servo_controller.sv]
// Testbench for the fuzzy light tracking servo controller: drives sample words,
// predicts each result in a scoreboard class and checks it. Depends on fltsc_pkg.
`timescale 1ns / 1ps

module tb_fuzzy_light_tracking_servo_controller;

  typedef struct {
    logic [7:0]         pos;
    logic signed [8:0]  angle;
    logic signed [15:0] action;
    logic               wrote;
    logic               fire;
  } servo_result_t;

  class servo_scoreboard;
    longint lu, ll, ru, rl, pmin, pmax;
    logic [31:0] period;
    longint pos;
    logic [31:0] last_ms;
    servo_result_t pending[$];
    int errors;

    function void reset_state();
      lu = -16384; ll = -8192; ru = 16384; rl = 8192;
      pmin = 50; pmax = 150; period = 20;
      pos = 100; last_ms = 0;
      pending.delete();
    endfunction

    function void set_reg(fltsc_pkg::reg_idx_t idx, logic [15:0] v);
      case (idx)
        fltsc_pkg::REG_LU: lu = longint'($signed(v));
        fltsc_pkg::REG_LL: ll = longint'($signed(v));
        fltsc_pkg::REG_RU: ru = longint'($signed(v));
        fltsc_pkg::REG_RL: rl = longint'($signed(v));
        fltsc_pkg::REG_PMIN: pmin = v[7:0];
        fltsc_pkg::REG_PMAX: pmax = v[7:0];
        fltsc_pkg::REG_PERIOD: period = {16'd0, v};
        default: ;
      endcase
    endfunction

    function longint fdiv(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && ((n < 0) != (d < 0))) q -= 1;
      return q;
    endfunction

    function longint rdiv(longint n, longint d);
      return fdiv(2 * n + d, 2 * d);
    endfunction

    function longint mn(longint a, longint b); return a < b ? a : b; endfunction
    function longint mx(longint a, longint b); return a > b ? a : b; endfunction

    function void note_word(logic [9:0] s[4], logic [31:0] now);
      longint x[4], dm[4], br[4];
      longint lo, hi, sum, r0, r1, r2, p0, p1, p2, p3, d01, d23, a2, n6, act, mag, stp;
      servo_result_t r;
      sum = 0; act = 0;
      for (int i = 0; i < 4; i++) begin
        x[i] = s[i];
        sum += x[i];
      end
      lo = mn(mn(x[0], x[1]), mn(x[2], x[3]));
      hi = mx(mx(x[0], x[1]), mx(x[2], x[3]));
      if (lo < 10) lo = 10;
      for (int i = 0; i < 4; i++) begin
        if (x[i] < lo || hi <= lo) dm[i] = 16384;
        else if (x[i] > hi) dm[i] = 0;
        else dm[i] = rdiv((hi - x[i]) * 16384, hi - lo);
        br[i] = 16384 - dm[i];
      end
      r0 = mx(mn(mn(br[0], dm[2]), dm[3]), mn(mn(dm[0], br[1]), mn(dm[2], dm[3])));
      r1 = mn(br[1], br[2]);
      r2 = mx(mn(mn(dm[0], dm[1]), br[3]), mn(mn(dm[0], dm[1]), mn(br[2], br[3])));
      if (r0 != 0 || r1 != 0 || r2 != 0) begin
        p0 = lu + rdiv((ll - lu) * r0, 16384) + 16384;
        p1 = ll + rdiv((lu - ll) * r1, 16384) + 16384;
        p2 = ru + rdiv((rl - ru) * r1, 16384) + 16384;
        p3 = rl + rdiv((ru - rl) * r2, 16384) + 16384;
        d01 = p1 - p0;
        d23 = p3 - p2;
        a2 = 2 * r0 * p0 + d01 * (r0 + r1) + 2 * r1 * (p2 - p1)
           + d23 * (r1 + r2) + 2 * r2 * (2 * 16384 - p3);
        n6 = 3 * r0 * p0 * p0 + 3 * (p2 * p2 - p1 * p1) * r1
           + 3 * (4 * 16384 * 16384 - p3 * p3) * r2
           + 3 * d01 * (r0 + r1) * p0 + d01 * d01 * (r0 + 2 * r1)
           + 3 * d23 * (r1 + r2) * p2 + d23 * d23 * (r1 + 2 * r2);
        if (a2 > 0) begin
          act = rdiv(n6, 3 * a2) - 16384;
          if (act > 16384) act = 16384;
          if (act < -16384) act = -16384;
        end
      end
      r.wrote = 0;
      if (32'(now - last_ms) > period) begin
        mag = act < 0 ? -act : act;
        stp = (mag * 10 + 8192) / 16384;
        if (act < 0) stp = -stp;
        pos -= stp;
        if (pos > pmax) pos = pmax;
        if (pos < pmin) pos = pmin;
        last_ms = now;
        r.wrote = 1;
      end
      r.pos = 8'(pos);
      r.angle = 9'(100 - pos);
      r.action = 16'(act);
      r.fire = sum > 60;
      pending.push_back(r);
    endfunction

    function void check_result(servo_result_t got);
      servo_result_t e;
      if (pending.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.pos !== e.pos) begin
        $error("servo_position expected %0d actual %0d", e.pos, got.pos); errors++;
      end
      if (got.angle !== e.angle) begin
        $error("angle_from_middle expected %0d actual %0d", e.angle, got.angle); errors++;
      end
      if (got.action !== e.action) begin
        $error("fuzzy_action expected %0d actual %0d", e.action, got.action); errors++;
      end
      if (got.wrote !== e.wrote) begin
        $error("position_written expected %0b actual %0b", e.wrote, got.wrote); errors++;
      end
      if (got.fire !== e.fire) begin
        $error("fire_seen expected %0b actual %0b", e.fire, got.fire); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, cfg_we, in_valid, in_ready, out_valid, out_ready;
  logic [2:0] cfg_index;
  logic [15:0] cfg_wdata;
  logic [9:0] in_sample_a, in_sample_b, in_sample_c, in_sample_d;
  logic [31:0] in_now_ms;
  logic [7:0] out_servo_position;
  logic signed [8:0] out_angle_from_middle;
  logic signed [15:0] out_fuzzy_action;
  logic out_position_written, out_fire_seen;

  servo_scoreboard sb;
  logic [31:0] clock_ms;
  longint cycles;
  bit long_hold;

  fuzzy_light_tracking_servo_controller dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 2000000) begin
        $display("fuzzy_light_tracking_servo_controller test failed");
        $finish;
      end
    end
  end

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // receiver: random stalls, one long hold-off on request
  initial begin
    servo_result_t got;
    int g;
    out_ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        out_ready <= 0;
        repeat (3000) @(posedge clk);
        long_hold = 0;
      end else begin
        g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
        if (g > 0) begin
          out_ready <= 0;
          repeat (g) @(posedge clk);
        end
      end
      out_ready <= 1;
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.pos = out_servo_position;
        got.angle = out_angle_from_middle;
        got.action = out_fuzzy_action;
        got.wrote = out_position_written;
        got.fire = out_fire_seen;
        sb.check_result(got);
      end
    end
  end

  task automatic write_reg(fltsc_pkg::reg_idx_t idx, logic [15:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic send_word(logic [9:0] a, logic [9:0] b, logic [9:0] c, logic [9:0] d,
                           logic [31:0] now);
    logic [9:0] s[4];
    s[0] = a; s[1] = b; s[2] = c; s[3] = d;
    in_valid <= 1;
    in_sample_a <= a; in_sample_b <= b; in_sample_c <= c; in_sample_d <= d;
    in_now_ms <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(s, now);
    in_valid <= 0;
    @(posedge clk);
  endtask

  // advance time mostly past the update period, sometimes short or wrapping
  task automatic send_random(bit bias);
    logic [9:0] v[4];
    int k;
    for (int i = 0; i < 4; i++) begin
      k = $urandom_range(0, 9);
      if (bias && k < 3) v[i] = $urandom_range(0, 30);
      else if (k == 3) v[i] = 10'h3ff;
      else v[i] = $urandom_range(0, 1023);
    end
    k = $urandom_range(0, 9);
    if (k < 6) clock_ms = clock_ms + sb.period + 1 + $urandom_range(0, 50);
    else if (k < 9) clock_ms = clock_ms + $urandom_range(0, 40);
    else clock_ms = $urandom;
    send_word(v[0], v[1], v[2], v[3], clock_ms);
    for (int g = gap_len(); g > 0; g--) @(posedge clk);
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    sb.errors = 0;
    long_hold = 0;
    clock_ms = 0;
    rst_n = 0; cfg_we = 0; cfg_index = fltsc_pkg::REG_LU; cfg_wdata = 0; in_valid = 0;
    in_sample_a = 0; in_sample_b = 0; in_sample_c = 0; in_sample_d = 0; in_now_ms = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, no contrast, dark, fire threshold, rule patterns, wrap
    send_word(0, 0, 0, 0, 0);
    send_word(1023, 1023, 1023, 1023, 21);
    send_word(15, 15, 15, 16, 42);
    send_word(15, 15, 15, 15, 63);
    send_word(1023, 0, 0, 0, 100);
    send_word(0, 1023, 0, 0, 200);
    send_word(0, 0, 1023, 0, 300);
    send_word(0, 0, 0, 1023, 400);
    send_word(0, 1023, 1023, 0, 500);
    send_word(1023, 0, 0, 1023, 600);
    send_word(5, 5, 5, 900, 700);
    send_word(900, 5, 5, 5, 710);
    send_word(900, 5, 5, 5, 720);
    send_word(900, 5, 5, 5, 721);
    send_word(500, 20, 700, 10, 32'hffff_fff0);
    send_word(10'h2aa, 10'h155, 10'h2aa, 10'h155, 32'h0000_0010);
    send_word(0, 0, 0, 1023, 32'h0000_0020);
    clock_ms = 32'h20;
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(fltsc_pkg::REG_PERIOD, 16'hffff);
          write_reg(fltsc_pkg::REG_PMIN, 0); write_reg(fltsc_pkg::REG_PMAX, 180);
          clock_ms = sb.last_ms;
          for (int i = 0; i < 6; i++) send_random(1);
          drain();
          write_reg(fltsc_pkg::REG_PERIOD, 0);
        end
        1: begin
          write_reg(fltsc_pkg::REG_LU, 16'h8000); write_reg(fltsc_pkg::REG_LL, 16'h7fff);
          write_reg(fltsc_pkg::REG_RU, 16'h7fff); write_reg(fltsc_pkg::REG_RL, 16'h8000);
        end
        2: begin
          write_reg(fltsc_pkg::REG_LU, -16'sd16384); write_reg(fltsc_pkg::REG_LL, 16'sd16384);
          write_reg(fltsc_pkg::REG_RU, 16'sd16384); write_reg(fltsc_pkg::REG_RL, -16'sd16384);
          write_reg(fltsc_pkg::REG_PMIN, 120); write_reg(fltsc_pkg::REG_PMAX, 60);
        end
        3: begin
          write_reg(fltsc_pkg::REG_LU, 16'(-12000)); write_reg(fltsc_pkg::REG_LL, 16'(-3000));
          write_reg(fltsc_pkg::REG_RU, 16'd14000); write_reg(fltsc_pkg::REG_RL, 16'd2000);
          write_reg(fltsc_pkg::REG_PMIN, 0); write_reg(fltsc_pkg::REG_PMAX, 255);
          write_reg(fltsc_pkg::REG_PERIOD, 5);
        end
        4: begin
          write_reg(fltsc_pkg::REG_LU, 16'($urandom)); write_reg(fltsc_pkg::REG_LL, 16'($urandom));
          write_reg(fltsc_pkg::REG_RU, 16'($urandom)); write_reg(fltsc_pkg::REG_RL, 16'($urandom));
        end
        default: begin
          write_reg(fltsc_pkg::REG_LU, -16'sd16384); write_reg(fltsc_pkg::REG_LL, -16'sd8192);
          write_reg(fltsc_pkg::REG_RU, 16'sd16384); write_reg(fltsc_pkg::REG_RL, 16'sd8192);
          write_reg(fltsc_pkg::REG_PMIN, 50); write_reg(fltsc_pkg::REG_PMAX, 150);
          write_reg(fltsc_pkg::REG_PERIOD, 20);
        end
      endcase
      if (ph == 3) long_hold = 1;
      for (int i = 0; i < 105; i++) send_random(ph != 4);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("fuzzy_light_tracking_servo_controller test passed");
    else
      $display("fuzzy_light_tracking_servo_controller test failed");
    $finish;
  end
endmodule
